/* hdl/asgr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_pkg
// Shared constants, codes and the SGR color table of the text parser.
// ----------------------------------------------------------------------------
package asgr_pkg;

  localparam int unsigned GLYPH_WIDTH = 8;
  localparam int unsigned LINE_HEIGHT = 16;
  localparam int unsigned PARAM_SLOTS = 8;

  localparam int unsigned NSLOTS  = PARAM_SLOTS + 1;
  localparam int unsigned SLOT_IW = $clog2(NSLOTS);
  localparam int unsigned WALK_W  = $clog2(NSLOTS + 1);

  localparam int unsigned COORD_W = 12;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_W   = 12;
  localparam int unsigned CFG_IW  = 1;

  localparam logic [CFG_IW-1:0] CFG_ENABLED     = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_LEFT_MARGIN = 1'd1;

  localparam logic [COORD_W-1:0] MARGIN_RESET = 12'd48;
  localparam logic [COORD_W-1:0] CURSOR_X_RST = 12'd48;
  localparam logic [COORD_W-1:0] CURSOR_Y_RST = 12'd85;

  localparam logic [BYTE_W-1:0] KEY_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] KEY_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] KEY_LBRK  = 8'h5B;
  localparam logic [BYTE_W-1:0] KEY_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] KEY_M     = 8'h6D;
  localparam logic [BYTE_W-1:0] KEY_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] KEY_NINE  = 8'h39;

  localparam logic [1:0] MODE_PLAIN   = 2'd0;
  localparam logic [1:0] MODE_BRACKET = 2'd1;
  localparam logic [1:0] MODE_PARAM   = 2'd2;

  localparam logic [BYTE_W-1:0] SGR_RESET  = 8'd0;
  localparam logic [BYTE_W-1:0] SGR_BOLD   = 8'd1;
  localparam logic [BYTE_W-1:0] SGR_FG_LO  = 8'd30;
  localparam logic [BYTE_W-1:0] SGR_FG_HI  = 8'd37;
  localparam logic [BYTE_W-1:0] SLOT_MAX   = 8'd255;

  function automatic logic [COLOR_W-1:0] fg_table(input logic [2:0] sel);
    logic [COLOR_W-1:0] rgb;
    case (sel)
      3'd0:    rgb = 24'h000000;
      3'd1:    rgb = 24'hF00000;
      3'd2:    rgb = 24'h00F000;
      3'd3:    rgb = 24'hF0F000;
      3'd4:    rgb = 24'h0000F0;
      3'd5:    rgb = 24'hF000F0;
      3'd6:    rgb = 24'h00F0F0;
      3'd7:    rgb = 24'hF0F0F0;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

/* hdl/ansi_sgr_text_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_sgr_text_parser
// Text byte to glyph front end with an ESC [ ... m foreground color parser.
// ----------------------------------------------------------------------------
// A byte is taken when the sequencer is idle and the result register is
// empty or being drained. While enabled, any byte but newline and escape
// outside a sequence, and any byte but '[' right after escape, gives one
// glyph beat with code, cursor position and color; newline, escape and
// parameter bytes give none. The 'm' that closes a sequence holds the input
// while the single slot read port and SGR compare unit walk the parameter
// slots one per cycle, passing over the slot after a bold attribute.
// No clearing pass follows reset.
module ansi_sgr_text_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [asgr_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [asgr_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [asgr_pkg::BYTE_W-1:0]   char_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [asgr_pkg::BYTE_W-1:0]   glyph_code_o,
  output logic [asgr_pkg::COORD_W-1:0]  pos_x_o,
  output logic [asgr_pkg::COORD_W-1:0]  pos_y_o,
  output logic [asgr_pkg::COLOR_W-1:0]  draw_color_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SGR  = 1'b1;

  localparam int unsigned SIW = asgr_pkg::SLOT_IW;
  localparam int unsigned WW  = asgr_pkg::WALK_W;
  localparam int unsigned CW  = asgr_pkg::COORD_W;
  localparam int unsigned BW  = asgr_pkg::BYTE_W;

  logic                         state_q, state_d;
  logic                         enabled_q;
  logic [CW-1:0]                margin_q;
  logic [1:0]                   mode_q, mode_d;
  logic [SIW-1:0]               count_q, count_d;
  logic [WW-1:0]                walk_q, walk_d;
  logic [asgr_pkg::COLOR_W-1:0] fg_q, fg_d;
  logic [CW-1:0]                cur_x_q, cur_x_d;
  logic [CW-1:0]                cur_y_q, cur_y_d;

  logic                         out_valid_q, out_valid_d;
  logic [BW-1:0]                glyph_q;
  logic [CW-1:0]                pos_x_q, pos_y_q;
  logic [asgr_pkg::COLOR_W-1:0] color_q;
  logic                         draw;

  logic [BW-1:0]                slot_value_q [asgr_pkg::NSLOTS];
  logic                         slot_filled_q [asgr_pkg::NSLOTS];
  logic                         wr_en;
  logic [SIW-1:0]               wr_addr;
  logic [BW-1:0]                wr_value;
  logic                         wr_filled;
  logic [SIW-1:0]               rd_addr;
  logic [BW-1:0]                rd_value;
  logic                         rd_filled;

  logic                         accept;
  logic                         is_digit;
  logic [CW-1:0]                acc;
  logic [BW-1:0]                digit;
  logic [BW-1:0]                fg_off;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign rd_addr   = (state_q == ST_SGR) ? walk_q[SIW-1:0] : count_q;
  assign rd_value  = slot_value_q[rd_addr];
  assign rd_filled = slot_filled_q[rd_addr];

  assign is_digit = (char_byte_i >= asgr_pkg::KEY_ZERO) &&
                    (char_byte_i <= asgr_pkg::KEY_NINE);
  assign digit    = char_byte_i - asgr_pkg::KEY_ZERO;
  assign acc      = {{(CW-BW){1'b0}}, rd_value} * CW'(10) + {{(CW-BW){1'b0}}, digit};
  assign fg_off   = rd_value - asgr_pkg::SGR_FG_LO;

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    count_d   = count_q;
    walk_d    = walk_q;
    fg_d      = fg_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    draw      = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = count_q;
    wr_value  = '0;
    wr_filled = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept && enabled_q) begin
          if (char_byte_i == asgr_pkg::KEY_NL) begin
            cur_y_d = cur_y_q + CW'(asgr_pkg::LINE_HEIGHT);
            cur_x_d = margin_q;
          end else if (mode_q == asgr_pkg::MODE_BRACKET) begin
            if (char_byte_i == asgr_pkg::KEY_LBRK) begin
              mode_d = asgr_pkg::MODE_PARAM;
            end else begin
              mode_d = asgr_pkg::MODE_PLAIN;
              draw   = 1'b1;
            end
          end else if (mode_q == asgr_pkg::MODE_PARAM) begin
            if (is_digit) begin
              wr_en     = 1'b1;
              wr_addr   = count_q;
              wr_value  = (acc > {{(CW-BW){1'b0}}, asgr_pkg::SLOT_MAX}) ?
                          asgr_pkg::SLOT_MAX : acc[BW-1:0];
              wr_filled = 1'b1;
            end else begin
              if (count_q < SIW'(asgr_pkg::PARAM_SLOTS)) begin
                count_d = count_q + SIW'(1);
              end
              wr_en   = 1'b1;
              wr_addr = count_d;
              if (char_byte_i == asgr_pkg::KEY_M) begin
                mode_d  = asgr_pkg::MODE_PLAIN;
                walk_d  = '0;
                state_d = ST_SGR;
              end else if (char_byte_i == asgr_pkg::KEY_SEMI) begin
                mode_d = asgr_pkg::MODE_PARAM;
              end else begin
                mode_d = asgr_pkg::MODE_PLAIN;
              end
            end
          end else begin
            if (char_byte_i == asgr_pkg::KEY_ESC) begin
              mode_d  = asgr_pkg::MODE_BRACKET;
              count_d = '0;
              wr_en   = 1'b1;
              wr_addr = '0;
            end else begin
              mode_d = asgr_pkg::MODE_PLAIN;
              draw   = 1'b1;
            end
          end
          if (draw) begin
            cur_x_d = cur_x_q + CW'(asgr_pkg::GLYPH_WIDTH);
          end
        end
      end
      ST_SGR: begin
        if (walk_q >= WW'(count_q)) begin
          state_d = ST_IDLE;
        end else begin
          walk_d = walk_q + WW'(1);
          if (rd_filled) begin
            if (rd_value == asgr_pkg::SGR_RESET) begin
              fg_d = '0;
            end else if (rd_value == asgr_pkg::SGR_BOLD) begin
              walk_d = walk_q + WW'(2);
            end else if ((rd_value >= asgr_pkg::SGR_FG_LO) &&
                         (rd_value <= asgr_pkg::SGR_FG_HI)) begin
              fg_d = asgr_pkg::fg_table(fg_off[2:0]);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (draw) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      enabled_q   <= 1'b0;
      margin_q    <= asgr_pkg::MARGIN_RESET;
      mode_q      <= asgr_pkg::MODE_PLAIN;
      count_q     <= '0;
      walk_q      <= '0;
      fg_q        <= '0;
      cur_x_q     <= asgr_pkg::CURSOR_X_RST;
      cur_y_q     <= asgr_pkg::CURSOR_Y_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      fg_q        <= fg_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          asgr_pkg::CFG_ENABLED:     enabled_q <= cfg_data_i[0];
          asgr_pkg::CFG_LEFT_MARGIN: margin_q  <= cfg_data_i[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw) begin
      glyph_q <= char_byte_i;
      pos_x_q <= cur_x_q;
      pos_y_q <= cur_y_q;
      color_q <= fg_q;
    end
    if (wr_en) begin
      slot_value_q[wr_addr]  <= wr_value;
      slot_filled_q[wr_addr] <= wr_filled;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign glyph_code_o = glyph_q;
  assign pos_x_o      = pos_x_q;
  assign pos_y_o      = pos_y_q;
  assign draw_color_o = color_q;

endmodule

/* hdl/asgr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_checker
// Port-level checks of the text parser, bound to its top level.
// ----------------------------------------------------------------------------
module asgr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [asgr_pkg::BYTE_W-1:0]   char_byte_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [asgr_pkg::BYTE_W-1:0]   glyph_code_o,
  input logic [asgr_pkg::COORD_W-1:0]  pos_x_o,
  input logic [asgr_pkg::COORD_W-1:0]  pos_y_o,
  input logic [asgr_pkg::COLOR_W-1:0]  draw_color_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(glyph_code_o) &&
    $stable(pos_x_o) && $stable(pos_y_o) && $stable(draw_color_o))
    else $error("glyph beat dropped or changed while stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o && out_valid_o && !out_ready_i))
    else $error("byte taken while a glyph beat is stalled");

  a_nl_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o &&
    (char_byte_i == asgr_pkg::KEY_NL) |=> !out_valid_o)
    else $error("newline produced a glyph beat");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("glyph beat during reset");

endmodule

bind ansi_sgr_text_parser asgr_checker u_asgr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .char_byte_i  (char_byte_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .glyph_code_o (glyph_code_o),
  .pos_x_o      (pos_x_o),
  .pos_y_o      (pos_y_o),
  .draw_color_o (draw_color_o)
);

/* bench/ansi_sgr_text_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_sgr_text_parser_tb
// Self-checking bench for the text byte to glyph parser with SGR colors.
// ----------------------------------------------------------------------------
// Text bytes go in over a valid/ready channel. A scoreboard class keeps its
// own copy of the cursor, the escape parser and the color, predicts the glyph
// beat each byte causes and checks every beat the parser hands out. Directed
// bytes cover the edge cases. Several random phases then run under different
// margins and with the terminal disabled, mostly as well-formed color
// sequences with random content, plus text, newlines and broken sequences.
// Random gaps fall on both channels. One phase stalls the output channel for
// a long stretch while the input keeps pushing.
// ----------------------------------------------------------------------------
module ansi_sgr_text_parser_tb;

  localparam int ITEMS         = 1600;
  localparam int PHASES        = 8;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int STALL_CYCLES  = 400;
  localparam int REPORT_MAX    = 10;

  localparam logic [asgr_pkg::COLOR_W-1:0] PALETTE [8] = '{
    24'h000000, 24'hF00000, 24'h00F000, 24'hF0F000,
    24'h0000F0, 24'hF000F0, 24'h00F0F0, 24'hF0F0F0
  };

  typedef struct packed {
    logic [asgr_pkg::BYTE_W-1:0]  glyph;
    logic [asgr_pkg::COORD_W-1:0] x;
    logic [asgr_pkg::COORD_W-1:0] y;
    logic [asgr_pkg::COLOR_W-1:0] rgb;
  } glyph_t;

  class glyph_scoreboard;
    bit                           en;
    logic [asgr_pkg::COORD_W-1:0] margin;
    logic [1:0]                   mode;
    int unsigned                  nslot;
    logic [asgr_pkg::BYTE_W-1:0]  slot_val [asgr_pkg::NSLOTS];
    bit                           slot_set [asgr_pkg::NSLOTS];
    logic [asgr_pkg::COLOR_W-1:0] fg;
    logic [asgr_pkg::COORD_W-1:0] cx;
    logic [asgr_pkg::COORD_W-1:0] cy;
    glyph_t                       due_glyphs [$];
    int unsigned                  taken, ignored, checked, errors;

    function new();
      en     = 1'b0;
      margin = asgr_pkg::MARGIN_RESET;
      mode   = asgr_pkg::MODE_PLAIN;
      nslot  = 0;
      foreach (slot_val[i]) begin
        slot_val[i] = '0;
        slot_set[i] = 1'b0;
      end
      fg = '0;
      cx = asgr_pkg::CURSOR_X_RST;
      cy = asgr_pkg::CURSOR_Y_RST;
      taken = 0; ignored = 0; checked = 0; errors = 0;
    endfunction

    function void set_reg(logic [asgr_pkg::CFG_IW-1:0] idx,
                          logic [asgr_pkg::CFG_W-1:0] data);
      if (idx == asgr_pkg::CFG_ENABLED) en = data[0];
      else if (idx == asgr_pkg::CFG_LEFT_MARGIN) margin = data[asgr_pkg::COORD_W-1:0];
    endfunction

    function void clear_slot(int unsigned idx);
      if (idx < asgr_pkg::NSLOTS) begin
        slot_val[idx] = '0;
        slot_set[idx] = 1'b0;
      end
    endfunction

    function void draw(logic [asgr_pkg::BYTE_W-1:0] c);
      due_glyphs.push_back('{c, cx, cy, fg});
      cx = cx + asgr_pkg::COORD_W'(asgr_pkg::GLYPH_WIDTH);
    endfunction

    function void run_sgr();
      logic [asgr_pkg::BYTE_W-1:0] attr;
      for (int unsigned i = 0; i < nslot && i < asgr_pkg::NSLOTS; i++) begin
        if (slot_set[i]) begin
          attr = slot_val[i];
          if (attr == asgr_pkg::SGR_RESET) fg = '0;
          else if (attr == asgr_pkg::SGR_BOLD) i++;
          else if (attr >= asgr_pkg::SGR_FG_LO && attr <= asgr_pkg::SGR_FG_HI)
            fg = PALETTE[3'(attr - asgr_pkg::SGR_FG_LO)];
        end
      end
    endfunction

    function void take_byte(logic [asgr_pkg::BYTE_W-1:0] c);
      int unsigned acc;
      if (!en) begin
        ignored++;
        return;
      end
      taken++;
      if (c == asgr_pkg::KEY_NL) begin
        cy = cy + asgr_pkg::COORD_W'(asgr_pkg::LINE_HEIGHT);
        cx = margin;
        return;
      end
      case (mode)
        asgr_pkg::MODE_BRACKET: begin
          if (c == asgr_pkg::KEY_LBRK) mode = asgr_pkg::MODE_PARAM;
          else begin
            mode = asgr_pkg::MODE_PLAIN;
            draw(c);
          end
        end
        asgr_pkg::MODE_PARAM: begin
          if (c >= asgr_pkg::KEY_ZERO && c <= asgr_pkg::KEY_NINE) begin
            if (nslot < asgr_pkg::NSLOTS) begin
              acc = int'(slot_val[nslot]) * 10 + int'(c - asgr_pkg::KEY_ZERO);
              slot_val[nslot] = (acc > asgr_pkg::SLOT_MAX) ?
                                asgr_pkg::SLOT_MAX : asgr_pkg::BYTE_W'(acc);
              slot_set[nslot] = 1'b1;
            end
          end else begin
            if (nslot < asgr_pkg::PARAM_SLOTS) nslot++;
            clear_slot(nslot);
            if (c == asgr_pkg::KEY_M) begin
              run_sgr();
              mode = asgr_pkg::MODE_PLAIN;
            end else if (c != asgr_pkg::KEY_SEMI) begin
              mode = asgr_pkg::MODE_PLAIN;
            end
          end
        end
        default: begin
          mode = asgr_pkg::MODE_PLAIN;
          if (c == asgr_pkg::KEY_ESC) begin
            mode  = asgr_pkg::MODE_BRACKET;
            nslot = 0;
            clear_slot(0);
          end else begin
            draw(c);
          end
        end
      endcase
    endfunction

    function void check_glyph(glyph_t got);
      glyph_t want;
      checked++;
      if (due_glyphs.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected glyph beat: code %02h x %0d y %0d rgb %06h",
                   got.glyph, got.x, got.y, got.rgb);
        return;
      end
      want = due_glyphs.pop_front();
      if (got.glyph !== want.glyph || got.x !== want.x || got.y !== want.y ||
          got.rgb !== want.rgb) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("glyph mismatch: want code %02h x %0d y %0d rgb %06h, %s",
                   want.glyph, want.x, want.y, want.rgb,
                   $sformatf("got code %02h x %0d y %0d rgb %06h",
                             got.glyph, got.x, got.y, got.rgb));
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i    = 1'b0;
  logic [asgr_pkg::CFG_IW-1:0]    cfg_idx_i   = '0;
  logic [asgr_pkg::CFG_W-1:0]     cfg_data_i  = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  logic [asgr_pkg::BYTE_W-1:0]    char_byte_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [asgr_pkg::BYTE_W-1:0]    glyph_code_o;
  logic [asgr_pkg::COORD_W-1:0]   pos_x_o;
  logic [asgr_pkg::COORD_W-1:0]   pos_y_o;
  logic [asgr_pkg::COLOR_W-1:0]   draw_color_o;

  glyph_scoreboard                sb;
  logic [asgr_pkg::BYTE_W-1:0]    byte_q [$];
  bit                             tx_burst, rx_burst;
  int                             rx_hold, rx_idle;

  ansi_sgr_text_parser uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_byte_i  (char_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .glyph_code_o (glyph_code_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .draw_color_o (draw_color_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("FAIL ansi_sgr_text_parser");
    $finish;
  end

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  initial begin
    rx_hold = 0;
    rx_idle = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) out_ready_i <= 1'b0;
      else if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else if (rx_idle > 0) begin
        out_ready_i <= 1'b0;
        rx_idle--;
      end else begin
        out_ready_i <= 1'b1;
        rx_idle = pick_gap(rx_burst);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        sb.check_glyph({glyph_code_o, pos_x_o, pos_y_o, draw_color_o});
    end
  end

  task automatic send_byte(logic [asgr_pkg::BYTE_W-1:0] b);
    bit took;
    in_valid_i  <= 1'b1;
    char_byte_i <= b;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      if (took) sb.take_byte(b);
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic play_queue();
    logic [asgr_pkg::BYTE_W-1:0] b;
    int g;
    while (byte_q.size() > 0) begin
      b = byte_q.pop_front();
      send_byte(b);
      g = pick_gap(tx_burst);
      if (g > 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.due_glyphs.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [asgr_pkg::CFG_IW-1:0] idx,
                           logic [asgr_pkg::CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void push_number(int unsigned v);
    logic [asgr_pkg::BYTE_W-1:0] d [$];
    do begin
      d.push_front(asgr_pkg::KEY_ZERO + asgr_pkg::BYTE_W'(v % 10));
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(0, 9) == 0) d.push_front(asgr_pkg::KEY_ZERO);
    foreach (d[i]) byte_q.push_back(d[i]);
  endfunction

  function automatic logic [asgr_pkg::BYTE_W-1:0] non_digit();
    logic [asgr_pkg::BYTE_W-1:0] b;
    do b = asgr_pkg::BYTE_W'($urandom_range(0, 255));
    while (b >= asgr_pkg::KEY_ZERO && b <= asgr_pkg::KEY_NINE);
    return b;
  endfunction

  function automatic void build_sgr();
    int n, r;
    n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(4, 11);
    byte_q.push_back(asgr_pkg::KEY_ESC);
    byte_q.push_back(asgr_pkg::KEY_LBRK);
    for (int k = 0; k < n; k++) begin
      if (k > 0) byte_q.push_back(asgr_pkg::KEY_SEMI);
      r = $urandom_range(0, 99);
      if (r < 8) ;
      else if (r < 18) push_number(asgr_pkg::SGR_RESET);
      else if (r < 28) push_number(asgr_pkg::SGR_BOLD);
      else if (r < 65) push_number($urandom_range(asgr_pkg::SGR_FG_LO, asgr_pkg::SGR_FG_HI));
      else if (r < 85) push_number($urandom_range(0, 99));
      else push_number($urandom_range(100, 70000));
      if ($urandom_range(0, 19) == 0) byte_q.push_back(asgr_pkg::KEY_NL);
    end
    r = $urandom_range(0, 99);
    if (r < 85) byte_q.push_back(asgr_pkg::KEY_M);
    else if (r < 92) byte_q.push_back(asgr_pkg::KEY_ESC);
    else byte_q.push_back(non_digit());
  endfunction

  function automatic void build_text();
    int len, r;
    len = $urandom_range(1, 10);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 15) byte_q.push_back(asgr_pkg::KEY_NL);
      else if (r < 85) byte_q.push_back(asgr_pkg::BYTE_W'($urandom_range(8'h20, 8'h7E)));
      else byte_q.push_back(asgr_pkg::BYTE_W'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_broken();
    byte_q.push_back(asgr_pkg::KEY_ESC);
    if ($urandom_range(0, 99) < 40) begin
      byte_q.push_back(asgr_pkg::BYTE_W'($urandom_range(0, 255)));
    end else begin
      byte_q.push_back(asgr_pkg::KEY_LBRK);
      push_number($urandom_range(0, 400));
      if ($urandom_range(0, 1)) byte_q.push_back(asgr_pkg::KEY_SEMI);
      byte_q.push_back($urandom_range(0, 1) ? asgr_pkg::KEY_ESC : non_digit());
    end
  endfunction

  function automatic void build_chunk();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) build_sgr();
    else if (r < 85) build_text();
    else build_broken();
  endfunction

  task automatic play_until(int unsigned target);
    while (sb.taken < target) begin
      build_chunk();
      play_queue();
    end
  endtask

  initial begin
    int unsigned target;
    logic [asgr_pkg::COORD_W-1:0] margin;
    rst_ni <= 1'b0;
    sb = new();
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    byte_q = '{8'h41, asgr_pkg::KEY_ESC};
    play_queue();
    settle();
    write_reg(asgr_pkg::CFG_ENABLED, asgr_pkg::CFG_W'(1));
    write_reg(asgr_pkg::CFG_LEFT_MARGIN, asgr_pkg::CFG_W'(4095));

    byte_q = '{8'h00, 8'hFF, asgr_pkg::KEY_NL, 8'h41, 8'h42, asgr_pkg::KEY_ESC, 8'h71,
               asgr_pkg::KEY_ESC, asgr_pkg::KEY_LBRK, 8'h39, 8'h39, 8'h39,
               asgr_pkg::KEY_SEMI, 8'h33, 8'h31,
               asgr_pkg::KEY_NL, asgr_pkg::KEY_M, 8'h5A,
               asgr_pkg::KEY_ESC, asgr_pkg::KEY_LBRK, 8'h31, asgr_pkg::KEY_SEMI,
               8'h33, 8'h34, asgr_pkg::KEY_SEMI,
               8'h33, 8'h32, asgr_pkg::KEY_M, 8'h67,
               asgr_pkg::KEY_ESC, asgr_pkg::KEY_LBRK, asgr_pkg::KEY_M,
               asgr_pkg::KEY_ESC, asgr_pkg::KEY_LBRK, 8'h30, asgr_pkg::KEY_ESC, 8'h6B};
    play_queue();
    settle();

    target = sb.taken;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: margin = '0;
        1: margin = '1;
        3: margin = asgr_pkg::MARGIN_RESET;
        4: margin = 12'd4088;
        6: margin = 12'd2048;
        default: margin = asgr_pkg::COORD_W'($urandom_range(0, 4095));
      endcase
      tx_burst = (p % 3 == 1);
      rx_burst = (p % 3 == 1);

      if (p == 3) begin
        write_reg(asgr_pkg::CFG_ENABLED, asgr_pkg::CFG_W'(0));
        repeat (6) build_chunk();
        play_queue();
        settle();
        write_reg(asgr_pkg::CFG_ENABLED, asgr_pkg::CFG_W'(1));
      end
      write_reg(asgr_pkg::CFG_LEFT_MARGIN, asgr_pkg::CFG_W'(margin));

      if (p == 4) begin
        rx_hold  = STALL_CYCLES;
        tx_burst = 1'b1;
        repeat (60) byte_q.push_back(asgr_pkg::BYTE_W'($urandom_range(8'h20, 8'h7E)));
        play_queue();
        tx_burst = 1'b0;
        settle();
      end

      target = target + ITEMS / PHASES;
      play_until(target);
      settle();
    end

    if (sb.due_glyphs.size() > 0) begin
      $display("%0d glyph beats never arrived", sb.due_glyphs.size());
      sb.errors += sb.due_glyphs.size();
    end
    $display("ran %0d parsed bytes and %0d ignored bytes, %0d glyph beats checked",
             sb.taken, sb.ignored, sb.checked);
    $display("%0d margin settings incl. 0 and 4095, one disabled phase, %0d-cycle output stall",
             PHASES + 1, STALL_CYCLES);
    if (sb.errors == 0) begin
      $display("PASS ansi_sgr_text_parser");
    end else begin
      $display("%0d failures", sb.errors);
      $display("FAIL ansi_sgr_text_parser");
    end
    $finish;
  end

endmodule

/* ansi_sgr_text_parser.f */
hdl/asgr_pkg.sv
hdl/ansi_sgr_text_parser.sv
hdl/asgr_checker.sv
bench/ansi_sgr_text_parser_tb.sv
